### sv/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg: shared types and constants of the text console character writer
// Command kinds, queue entry and result layouts, engine states, default sizes.
// ----------------------------------------------------------------------------
package tccw_pkg;

    localparam int ROWS_DEF    = 25;
    localparam int COLUMNS_DEF = 80;

    localparam int CHAR_W     = 8;
    localparam int ADDR_IN_W  = 11;
    localparam int CURSOR_W   = 11;
    localparam int CELL_W     = 16;
    localparam int TDATA_W    = 32;
    localparam int TAB_STEP   = 4;

    localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'd32;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [2:0] {
        CMD_READ,
        CMD_NEWLINE,
        CMD_TAB,
        CMD_BACKSPACE,
        CMD_PRINT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [CHAR_W-1:0]      char_code;
        logic [CHAR_W-1:0]      attribute;
        logic [ADDR_IN_W-1:0]   read_address;
    } cmd_t;

    // cursor sits in the low bits
    typedef struct packed {
        logic                   scrolled;
        logic [CELL_W-1:0]      read_data;
        logic [CURSOR_W-1:0]    cursor;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCROLL
    } back_state_t;

endpackage

### sv/tccw_front.sv
// ----------------------------------------------------------------------------
// tccw_front: input beat register and command decode
// Takes input beats, sorts them into command kinds, hands them to the queue.
// ----------------------------------------------------------------------------
module tccw_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [tccw_pkg::TDATA_W-1:0] s_tdata,
    input  logic                        s_tuser,
    input  logic                        init_done,
    output tccw_pkg::cmd_t              cmd,
    output logic                        cmd_valid,
    input  logic                        cmd_ready
);
    import tccw_pkg::*;

    logic  hold_valid_reg;
    logic  hold_valid_next;
    cmd_t  hold_reg;
    cmd_t  dec;
    logic  accept;

    always_comb begin
        dec.char_code    = s_tdata[CHAR_W-1:0];
        dec.attribute    = s_tdata[2*CHAR_W-1:CHAR_W];
        dec.read_address = s_tdata[2*CHAR_W+ADDR_IN_W-1:2*CHAR_W];
        if (s_tuser == OP_READ) begin
            dec.kind = CMD_READ;
        end else begin
            case (dec.char_code)
                CHAR_NEWLINE:   dec.kind = CMD_NEWLINE;
                CHAR_TAB:       dec.kind = CMD_TAB;
                CHAR_BACKSPACE: dec.kind = CMD_BACKSPACE;
                default:        dec.kind = CMD_PRINT;
            endcase
        end
    end

    // no beats taken while the screen store is being wiped
    assign s_tready = init_done && (!hold_valid_reg || cmd_ready);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (accept) begin
            hold_valid_next = 1'b1;
        end else if (cmd_ready) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hold_reg <= dec;
        end
    end

    assign cmd       = hold_reg;
    assign cmd_valid = hold_valid_reg;

endmodule

### sv/tccw_queue.sv
// ----------------------------------------------------------------------------
// tccw_queue: two-entry command queue
// Decouples command decode from the screen engine.
// ----------------------------------------------------------------------------
module tccw_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  tccw_pkg::cmd_t in_cmd,
    input  logic           in_valid,
    output logic           in_ready,
    output tccw_pkg::cmd_t out_cmd,
    output logic           out_valid,
    input  logic           out_ready
);
    import tccw_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

### sv/tccw_back.sv
// ----------------------------------------------------------------------------
// tccw_back: screen engine
// Holds the cell store as a ring of rows, the cursor and the result register.
// A scroll moves the top-row offset and wipes one row.
// ----------------------------------------------------------------------------
module tccw_back #(
    parameter int ROWS    = tccw_pkg::ROWS_DEF,
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  tccw_pkg::cmd_t cmd,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    output logic           init_done,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output tccw_pkg::rsp_t rsp
);
    import tccw_pkg::*;

    localparam int CELLS       = ROWS * COLUMNS;
    localparam int AW          = $clog2(CELLS);
    localparam int CW          = $clog2(CELLS + COLUMNS);
    localparam int COLW        = $clog2(COLUMNS + TAB_STEP);
    localparam int SCROLL_BASE = CELLS - COLUMNS;

    back_state_t     state_reg, state_next;
    logic [CW-1:0]   cur_reg, cur_next;
    logic [COLW-1:0] col_reg, col_next;
    logic [AW-1:0]   top_reg, top_next;      // physical start of the top row
    logic [AW-1:0]   scan_reg, scan_next;
    logic            rd_zero_reg, rd_zero_next;
    logic            out_valid_reg, out_valid_next;
    rsp_t            out_reg, out_next;

    logic [CELL_W-1:0] cell_mem [CELLS];
    logic [CELL_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [CELL_W-1:0] mem_wdata;

    logic [CW-1:0]     cur_calc;
    logic [COLW-1:0]   col_calc, col_sum;
    logic              put_we;
    logic [AW-1:0]     put_addr;
    logic [CELL_W-1:0] put_data;
    logic              pop;
    logic [AW-1:0]     row_end;

    // logical cell index to physical, offset by the top row
    function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] x,
                                              input logic [AW-1:0] top);
        logic [AW:0] s;
        s = {1'b0, x} + {1'b0, top};
        if (s >= (AW+1)'(CELLS)) begin
            s = s - (AW+1)'(CELLS);
        end
        return s[AW-1:0];
    endfunction

    assign init_done = (state_reg != ST_CLEAR);
    assign cmd_ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp_ready);
    assign pop       = cmd_valid && cmd_ready;
    assign row_end   = top_reg + AW'(COLUMNS - 1);
    assign mem_raddr = to_phys(AW'(cmd.read_address), top_reg);

    // cursor update for a put
    always_comb begin
        cur_calc = cur_reg;
        col_calc = col_reg;
        col_sum  = col_reg + COLW'(TAB_STEP);
        put_we   = 1'b0;
        put_addr = to_phys(cur_reg[AW-1:0], top_reg);
        put_data = {cmd.attribute, cmd.char_code};
        case (cmd.kind)
            CMD_NEWLINE: begin
                cur_calc = cur_reg - CW'(col_reg) + CW'(COLUMNS);
                col_calc = '0;
            end
            CMD_TAB: begin
                cur_calc = cur_reg + CW'(TAB_STEP);
                col_calc = (col_sum >= COLW'(COLUMNS)) ? col_sum - COLW'(COLUMNS) : col_sum;
            end
            CMD_BACKSPACE: begin
                if (cur_reg != '0) begin
                    cur_calc = cur_reg - 1'b1;
                    col_calc = (col_reg == '0) ? COLW'(COLUMNS - 1) : col_reg - 1'b1;
                end
                put_we   = 1'b1;
                put_addr = to_phys(cur_calc[AW-1:0], top_reg);
                put_data = {cmd.attribute, CHAR_SPACE};
            end
            CMD_PRINT: begin
                cur_calc = cur_reg + 1'b1;
                col_calc = (col_reg == COLW'(COLUMNS - 1)) ? '0 : col_reg + 1'b1;
                put_we   = 1'b1;
            end
            default: begin
                cur_calc = cur_reg;
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        col_next       = col_reg;
        top_next       = top_reg;
        scan_next      = scan_reg;
        rd_zero_next   = rd_zero_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_waddr      = put_addr;
        mem_wdata      = put_data;
        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = scan_reg;
                mem_wdata = '0;
                if (scan_reg == AW'(CELLS - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (pop) begin
                    if (cmd.kind == CMD_READ) begin
                        rd_zero_next = !(32'(cmd.read_address) < 32'(CELLS));
                        state_next   = ST_READ;
                    end else begin
                        mem_we   = put_we;
                        col_next = col_calc;
                        if (cur_calc >= CW'(CELLS)) begin
                            cur_next   = CW'(SCROLL_BASE);
                            col_next   = '0;
                            scan_next  = top_reg;
                            state_next = ST_SCROLL;
                        end else begin
                            cur_next           = cur_calc;
                            out_valid_next     = 1'b1;
                            out_next.cursor    = CURSOR_W'(cur_calc);
                            out_next.read_data = '0;
                            out_next.scrolled  = 1'b0;
                        end
                    end
                end
            end
            ST_READ: begin
                out_valid_next     = 1'b1;
                out_next.cursor    = CURSOR_W'(cur_reg);
                out_next.read_data = rd_zero_reg ? '0 : rd_data_reg;
                out_next.scrolled  = 1'b0;
                state_next         = ST_IDLE;
            end
            ST_SCROLL: begin
                // old top row becomes the blank bottom row
                mem_we    = 1'b1;
                mem_waddr = scan_reg;
                mem_wdata = '0;
                if (scan_reg == row_end) begin
                    top_next = (top_reg == AW'(SCROLL_BASE)) ? '0
                                                              : top_reg + AW'(COLUMNS);
                    out_valid_next     = 1'b1;
                    out_next.cursor    = CURSOR_W'(cur_reg);
                    out_next.read_data = '0;
                    out_next.scrolled  = 1'b1;
                    state_next         = ST_IDLE;
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            cur_reg       <= '0;
            col_reg       <= '0;
            top_reg       <= '0;
            scan_reg      <= '0;
            rd_zero_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            col_reg       <= col_next;
            top_reg       <= top_next;
            scan_reg      <= scan_next;
            rd_zero_reg   <= rd_zero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= cell_mem[mem_raddr];
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

### sv/text_console_char_writer.sv
// ----------------------------------------------------------------------------
// text_console_char_writer: text screen writer with cursor and scroll
// Put beats write characters and move the cursor; read beats return a cell.
//
//   port group   dir   payload
//   s_*          in    tuser: opcode; tdata: char_code, attribute, read_address
//   m_*          out   tdata: cursor, read_data, scrolled
//
// A put is done in the idle state; a read also passes ST_READ (registered cell store read).
// A put that scrolls then passes ST_SCROLL to wipe one row of the cell ring.
// After reset the whole store is wiped in ST_CLEAR, with s_tready low.
// A 2-entry queue and the result register let either side stall alone.
// ----------------------------------------------------------------------------
module text_console_char_writer #(
    parameter int ROWS    = tccw_pkg::ROWS_DEF,
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [7:0] char_code, [15:8] attribute, [26:16] read_address, rest zero
    input  logic [tccw_pkg::TDATA_W-1:0] s_tdata,
    // [0] opcode
    input  logic                         s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [10:0] cursor, [26:11] read_data, [27] scrolled, rest zero
    output logic [tccw_pkg::TDATA_W-1:0] m_tdata
);
    import tccw_pkg::*;

    cmd_t front_cmd, queue_cmd;
    logic front_valid, front_ready;
    logic queue_valid, queue_ready;
    logic init_done;
    rsp_t rsp;

    tccw_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .init_done (init_done),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready)
    );

    tccw_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_cmd    (front_cmd),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .out_cmd   (queue_cmd),
        .out_valid (queue_valid),
        .out_ready (queue_ready)
    );

    tccw_back #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (queue_cmd),
        .cmd_valid (queue_valid),
        .cmd_ready (queue_ready),
        .init_done (init_done),
        .rsp_valid (m_tvalid),
        .rsp_ready (m_tready),
        .rsp       (rsp)
    );

    assign m_tdata = {(TDATA_W - $bits(rsp_t))'(0), rsp};

    // scroll always leaves the cursor at the start of the bottom row
    a_scroll_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[27] |-> m_tdata[10:0] == CURSOR_W'(ROWS*COLUMNS - COLUMNS))
        else $error("scroll result with cursor off the bottom row start");

    // no beat taken during the store wipe
    a_no_accept_in_wipe: assert property (@(posedge aclk) disable iff (!aresetn)
        !init_done |-> !s_tready)
        else $error("input accepted during store wipe");

    // cell data only comes from reads, which never scroll
    a_read_no_scroll: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[26:11] != '0) |-> !m_tdata[27])
        else $error("result carries both cell data and scroll flag");

endmodule
